[design/rtss_pkg.sv]
// ---------------------------------------------------------------------------
// rtss_pkg: shared constants for the resistive touch scan sequencer
// Register indexes, reset values, scan phase codes and panel drive codes.
// ---------------------------------------------------------------------------
package rtss_pkg;

    // Default ADC resolution and fixed field widths.
    localparam int ADC_WIDTH_DEF  = 12;
    localparam int GAP_W          = 12;
    localparam int DELAY_W        = 8;
    localparam int PRESSURE_W     = 13;
    localparam int COORD_W        = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int PHASE_W        = 3;
    localparam int DRIVE_W        = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PENDOWN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PENUP      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSITION = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE       = 3'd5;

    // Configuration reset values.
    localparam logic [GAP_W-1:0]   PENDOWN_GAP_RST   = 12'd400;
    localparam logic [GAP_W-1:0]   PENUP_GAP_RST     = 12'd2000;
    localparam logic [DELAY_W-1:0] SETTLE_DELAY_RST  = 8'd2;
    localparam logic [DELAY_W-1:0] TRANS_DELAY_RST   = 8'd20;
    localparam logic [DELAY_W-1:0] IDLE_DELAY_RST    = 8'd100;

    // Scan phases; anything from PH_ABNORMAL upward restarts the scan.
    localparam logic [PHASE_W-1:0] PH_PRESS1   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS2   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_XPOS     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_YPOS     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ABNORMAL = 3'd4;

    // Panel drive modes and ADC channel selects.
    localparam logic [DRIVE_W-1:0] DRIVE_PRESSURE = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_X        = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_Y        = 2'd2;
    localparam logic               CH_NINE        = 1'b0;
    localparam logic               CH_EIGHT       = 1'b1;

    // Pen-up sample coordinate and pressure ceiling.
    localparam logic [COORD_W-1:0]    PEN_UP_COORD = 16'hFFFF;
    localparam logic [PRESSURE_W-1:0] PRESSURE_MAX = 13'h1FFF;

endpackage

[design/resistive_touch_scan_sequencer.sv]
// ---------------------------------------------------------------------------
// resistive_touch_scan_sequencer: 4-wire resistive panel scan sequencer
// Steps through two pressure reads, an X read and a Y read, one ADC
// conversion per request, and reports the next drive, channel and delay.
// ---------------------------------------------------------------------------
// Usage:
//   Each ADC conversion enters as a request on the i_valid / o_ready channel
//   (i_adc_value). Each request yields exactly one result on the o_valid /
//   i_ready channel: drive mode, next channel, delay, and optionally a touch
//   or pen-up sample. Configuration goes through the plain write port
//   (i_cfg_we, i_cfg_index, i_cfg_data) while no request is in flight.
//   A request passes one input register, then the scan logic into the
//   result register. Throughput is one request per cycle while the
//   receiver keeps up; the scan phase advances as a request leaves the
//   input register, so a new request may follow in the very next cycle.
//   When the receiver stalls, the result register holds and the input
//   register fills; o_ready drops only once both are occupied.
//   Reset (synchronous, active low) empties both stages, loads the register
//   defaults (disabled) and puts the scan in its abnormal phase, so the first
//   enabled conversion restarts the scan with the idle delay.
// ---------------------------------------------------------------------------
module resistive_touch_scan_sequencer #(
    parameter int ADC_WIDTH = rtss_pkg::ADC_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [rtss_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rtss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // conversion requests
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ADC_WIDTH-1:0]              i_adc_value,
    // results
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_accepted,
    output logic [rtss_pkg::DRIVE_W-1:0]      o_drive_mode,
    output logic                              o_next_channel,
    output logic [rtss_pkg::DELAY_W-1:0]      o_delay_ticks,
    output logic                              o_sample_valid,
    output logic [rtss_pkg::PRESSURE_W-1:0]   o_pressure,
    output logic [rtss_pkg::COORD_W-1:0]      o_x_pos,
    output logic [rtss_pkg::COORD_W-1:0]      o_y_pos
);

    // Compare width covers a reading plus a gap without wrap.
    localparam int CW = ((ADC_WIDTH > rtss_pkg::GAP_W) ? ADC_WIDTH : rtss_pkg::GAP_W) + 1;
    // Signed width for gap - (first - second).
    localparam int PW = CW + 2;

    // Configuration registers.
    logic                            r_enable;
    logic [rtss_pkg::GAP_W-1:0]      r_pendown_gap;
    logic [rtss_pkg::GAP_W-1:0]      r_penup_gap;
    logic [rtss_pkg::DELAY_W-1:0]    r_settle_delay;
    logic [rtss_pkg::DELAY_W-1:0]    r_trans_delay;
    logic [rtss_pkg::DELAY_W-1:0]    r_idle_delay;

    // Scan state.
    logic [rtss_pkg::PHASE_W-1:0]    r_phase, n_phase;
    logic [ADC_WIDTH-1:0]            r_first, n_first;
    logic [ADC_WIDTH-1:0]            r_second, n_second;
    logic [ADC_WIDTH-1:0]            r_x_read, n_x_read;
    logic                            r_pen_up, n_pen_up;

    // Input stage.
    logic                            r_in_valid;
    logic [ADC_WIDTH-1:0]            r_adc;

    // Result stage.
    logic                            r_out_valid;
    logic                            r_accepted, n_accepted;
    logic [rtss_pkg::DRIVE_W-1:0]    r_drive, n_drive;
    logic                            r_chan, n_chan;
    logic [rtss_pkg::DELAY_W-1:0]    r_delay, n_delay;
    logic                            r_smp_valid, n_smp_valid;
    logic [rtss_pkg::PRESSURE_W-1:0] r_pressure, n_pressure;
    logic [rtss_pkg::COORD_W-1:0]    r_x_pos, n_x_pos;
    logic [rtss_pkg::COORD_W-1:0]    r_y_pos, n_y_pos;

    logic                            out_free;
    logic                            stage_go;
    logic [CW-1:0]                   first_ext;
    logic [CW-1:0]                   second_ext;
    logic [CW-1:0]                   pen_down_sum;
    logic [CW-1:0]                   pen_up_sum;
    logic signed [PW-1:0]            press_raw;

    // Handshake: the result register frees when empty or taken, and the
    // input register moves forward whenever the result register is free.
    assign out_free = !r_out_valid || i_ready;
    assign stage_go = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_pendown_gap  <= rtss_pkg::PENDOWN_GAP_RST;
            r_penup_gap    <= rtss_pkg::PENUP_GAP_RST;
            r_settle_delay <= rtss_pkg::SETTLE_DELAY_RST;
            r_trans_delay  <= rtss_pkg::TRANS_DELAY_RST;
            r_idle_delay   <= rtss_pkg::IDLE_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtss_pkg::REG_ENABLE:     r_enable       <= i_cfg_data[0];
                rtss_pkg::REG_PENDOWN:    r_pendown_gap  <= i_cfg_data;
                rtss_pkg::REG_PENUP:      r_penup_gap    <= i_cfg_data;
                rtss_pkg::REG_SETTLE:     r_settle_delay <= i_cfg_data[rtss_pkg::DELAY_W-1:0];
                rtss_pkg::REG_TRANSITION: r_trans_delay  <= i_cfg_data[rtss_pkg::DELAY_W-1:0];
                rtss_pkg::REG_IDLE:       r_idle_delay   <= i_cfg_data[rtss_pkg::DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pressure comparisons and touch pressure, all without wrap.
    assign first_ext    = CW'(r_first);
    assign second_ext   = CW'(r_adc);
    assign pen_down_sum = second_ext + CW'(r_pendown_gap);
    assign pen_up_sum   = second_ext + CW'(r_penup_gap);
    assign press_raw    = $signed(PW'(r_pendown_gap)) - $signed(PW'(r_first))
                        + $signed(PW'(r_second));

    // Scan step for the request in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_second    = r_second;
        n_x_read    = r_x_read;
        n_pen_up    = r_pen_up;
        n_accepted  = r_enable;
        n_drive     = rtss_pkg::DRIVE_PRESSURE;
        n_chan      = rtss_pkg::CH_NINE;
        n_delay     = '0;
        n_smp_valid = 1'b0;
        n_pressure  = '0;
        n_x_pos     = '0;
        n_y_pos     = '0;
        if (r_enable) begin
            case (r_phase)
                rtss_pkg::PH_PRESS1: begin
                    n_first = r_adc;
                    n_phase = rtss_pkg::PH_PRESS2;
                    n_chan  = rtss_pkg::CH_EIGHT;
                end
                rtss_pkg::PH_PRESS2: begin
                    n_second = r_adc;
                    n_phase  = rtss_pkg::PH_PRESS1;
                    if (pen_down_sum > first_ext) begin
                        // Pen is down: go measure X.
                        n_phase = rtss_pkg::PH_XPOS;
                        n_drive = rtss_pkg::DRIVE_X;
                        n_delay = r_settle_delay;
                    end else if (pen_up_sum < first_ext) begin
                        // Pen is up: report the lift once.
                        n_delay = r_idle_delay;
                        if (!r_pen_up) begin
                            n_pen_up    = 1'b1;
                            n_smp_valid = 1'b1;
                            n_x_pos     = rtss_pkg::PEN_UP_COORD;
                            n_y_pos     = rtss_pkg::PEN_UP_COORD;
                        end
                    end else begin
                        n_delay = r_trans_delay;
                    end
                end
                rtss_pkg::PH_XPOS: begin
                    n_x_read = r_adc;
                    n_phase  = rtss_pkg::PH_YPOS;
                    n_drive  = rtss_pkg::DRIVE_Y;
                    n_chan   = rtss_pkg::CH_EIGHT;
                    n_delay  = r_settle_delay;
                end
                rtss_pkg::PH_YPOS: begin
                    // Full reading: emit the touch sample with clamped pressure.
                    n_smp_valid = 1'b1;
                    if (press_raw < 0) begin
                        n_pressure = '0;
                    end else if (press_raw > $signed(PW'(rtss_pkg::PRESSURE_MAX))) begin
                        n_pressure = rtss_pkg::PRESSURE_MAX;
                    end else begin
                        n_pressure = press_raw[rtss_pkg::PRESSURE_W-1:0];
                    end
                    n_x_pos  = rtss_pkg::COORD_W'(r_x_read);
                    n_y_pos  = rtss_pkg::COORD_W'(r_adc);
                    n_pen_up = 1'b0;
                    n_phase  = rtss_pkg::PH_PRESS1;
                    n_delay  = r_settle_delay;
                end
                default: begin
                    // Abnormal phase: restart the scan after the idle delay.
                    n_phase = rtss_pkg::PH_PRESS1;
                    n_delay = r_idle_delay;
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_adc <= i_adc_value;
        end
    end

    // Scan state advances as a request moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rtss_pkg::PH_ABNORMAL;
            r_first  <= '0;
            r_second <= '0;
            r_x_read <= '0;
            r_pen_up <= 1'b1;
        end else if (stage_go) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_x_read <= n_x_read;
            r_pen_up <= n_pen_up;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (stage_go) begin
            r_accepted  <= n_accepted;
            r_drive     <= n_drive;
            r_chan      <= n_chan;
            r_delay     <= n_delay;
            r_smp_valid <= n_smp_valid;
            r_pressure  <= n_pressure;
            r_x_pos     <= n_x_pos;
            r_y_pos     <= n_y_pos;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_drive_mode   = r_drive;
    assign o_next_channel = r_chan;
    assign o_delay_ticks  = r_delay;
    assign o_sample_valid = r_smp_valid;
    assign o_pressure     = r_pressure;
    assign o_x_pos        = r_x_pos;
    assign o_y_pos        = r_y_pos;

    // A sample is only ever carried by a processed request.
    a_sample_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_smp_valid) |-> r_accepted)
        else $error("sample reported on a request that was not processed");

    // A request ignored while disabled carries an all-zero result.
    a_ignored_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_accepted) |-> (r_drive == rtss_pkg::DRIVE_PRESSURE
            && r_chan == rtss_pkg::CH_NINE && r_delay == '0 && !r_smp_valid
            && r_pressure == '0 && r_x_pos == '0 && r_y_pos == '0))
        else $error("ignored request produced a nonzero result");

    // The X scan is always read on channel nine and never carries a sample.
    a_x_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_drive == rtss_pkg::DRIVE_X)
            |-> (r_chan == rtss_pkg::CH_NINE && !r_smp_valid))
        else $error("X scan result has wrong channel or a sample");

    // Once an enabled request has passed, the scan phase is always a valid one.
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_go && r_enable) |=> (r_phase == rtss_pkg::PH_PRESS1
            || r_phase == rtss_pkg::PH_PRESS2 || r_phase == rtss_pkg::PH_XPOS
            || r_phase == rtss_pkg::PH_YPOS))
        else $error("scan phase left the legal range");

endmodule

[test/tb_resistive_touch_scan_sequencer.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_resistive_touch_scan_sequencer: self-checking bench for the touch scan
// Streams ADC conversions through the scan sequencer under several register
// settings and checks each result against a cycle-free scan predictor.
// ---------------------------------------------------------------------------
module tb_resistive_touch_scan_sequencer;

    localparam int ADC_MAX        = (1 << rtss_pkg::ADC_WIDTH_DEF) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct {
        logic                            accepted;
        logic [rtss_pkg::DRIVE_W-1:0]    drive_mode;
        logic                            next_channel;
        logic [rtss_pkg::DELAY_W-1:0]    delay_ticks;
        logic                            sample_valid;
        logic [rtss_pkg::PRESSURE_W-1:0] pressure;
        logic [rtss_pkg::COORD_W-1:0]    x_pos;
        logic [rtss_pkg::COORD_W-1:0]    y_pos;
    } t_scan_result;

    // Block ports; every input starts at a known value.
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [rtss_pkg::CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [rtss_pkg::CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                               i_valid     = 1'b0;
    logic                               o_ready;
    logic [rtss_pkg::ADC_WIDTH_DEF-1:0] i_adc_value = '0;
    logic                               o_valid;
    logic                               i_ready     = 1'b0;
    logic                               o_accepted;
    logic [rtss_pkg::DRIVE_W-1:0]       o_drive_mode;
    logic                               o_next_channel;
    logic [rtss_pkg::DELAY_W-1:0]       o_delay_ticks;
    logic                               o_sample_valid;
    logic [rtss_pkg::PRESSURE_W-1:0]    o_pressure;
    logic [rtss_pkg::COORD_W-1:0]       o_x_pos;
    logic [rtss_pkg::COORD_W-1:0]       o_y_pos;

    // Predictor copy of the registers and of the scan state.
    logic                               cfg_enable     = 1'b0;
    logic [rtss_pkg::GAP_W-1:0]         cfg_pendown    = rtss_pkg::PENDOWN_GAP_RST;
    logic [rtss_pkg::GAP_W-1:0]         cfg_penup      = rtss_pkg::PENUP_GAP_RST;
    logic [rtss_pkg::DELAY_W-1:0]       cfg_settle     = rtss_pkg::SETTLE_DELAY_RST;
    logic [rtss_pkg::DELAY_W-1:0]       cfg_transition = rtss_pkg::TRANS_DELAY_RST;
    logic [rtss_pkg::DELAY_W-1:0]       cfg_idle       = rtss_pkg::IDLE_DELAY_RST;
    logic [rtss_pkg::PHASE_W-1:0]       scan_phase     = rtss_pkg::PH_ABNORMAL;
    logic [rtss_pkg::ADC_WIDTH_DEF-1:0] first_reading  = '0;
    logic [rtss_pkg::ADC_WIDTH_DEF-1:0] second_reading = '0;
    logic [rtss_pkg::ADC_WIDTH_DEF-1:0] x_reading      = '0;
    logic                               pen_lifted     = 1'b1;

    t_scan_result expected_scans[$];
    int           scan_mismatches = 0;
    bit           sender_gaps     = 1'b1;
    bit           receiver_gaps   = 1'b1;
    int           drain_hold      = 0;

    resistive_touch_scan_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_adc_value    (i_adc_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_accepted     (o_accepted),
        .o_drive_mode   (o_drive_mode),
        .o_next_channel (o_next_channel),
        .o_delay_ticks  (o_delay_ticks),
        .o_sample_valid (o_sample_valid),
        .o_pressure     (o_pressure),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Advance the scan state by one conversion and return the result it yields.
    function automatic t_scan_result predict_scan_step(
        input logic [rtss_pkg::ADC_WIDTH_DEF-1:0] value);
        t_scan_result r;
        int           p;
        r = '{default: '0};
        if (!cfg_enable) begin
            return r;
        end
        r.accepted = 1'b1;
        case (scan_phase)
            rtss_pkg::PH_PRESS1: begin
                first_reading  = value;
                scan_phase     = rtss_pkg::PH_PRESS2;
                r.drive_mode   = rtss_pkg::DRIVE_PRESSURE;
                r.next_channel = rtss_pkg::CH_EIGHT;
                r.delay_ticks  = '0;
            end
            rtss_pkg::PH_PRESS2: begin
                second_reading = value;
                if (int'(second_reading) + int'(cfg_pendown) > int'(first_reading)) begin
                    scan_phase     = rtss_pkg::PH_XPOS;
                    r.drive_mode   = rtss_pkg::DRIVE_X;
                    r.next_channel = rtss_pkg::CH_NINE;
                    r.delay_ticks  = cfg_settle;
                end else if (int'(second_reading) + int'(cfg_penup)
                             < int'(first_reading)) begin
                    // A lift reports one pen-up sample, further lifts stay silent.
                    if (!pen_lifted) begin
                        pen_lifted     = 1'b1;
                        r.sample_valid = 1'b1;
                        r.x_pos        = rtss_pkg::PEN_UP_COORD;
                        r.y_pos        = rtss_pkg::PEN_UP_COORD;
                    end
                    scan_phase     = rtss_pkg::PH_PRESS1;
                    r.drive_mode   = rtss_pkg::DRIVE_PRESSURE;
                    r.next_channel = rtss_pkg::CH_NINE;
                    r.delay_ticks  = cfg_idle;
                end else begin
                    scan_phase     = rtss_pkg::PH_PRESS1;
                    r.drive_mode   = rtss_pkg::DRIVE_PRESSURE;
                    r.next_channel = rtss_pkg::CH_NINE;
                    r.delay_ticks  = cfg_transition;
                end
            end
            rtss_pkg::PH_XPOS: begin
                x_reading      = value;
                scan_phase     = rtss_pkg::PH_YPOS;
                r.drive_mode   = rtss_pkg::DRIVE_Y;
                r.next_channel = rtss_pkg::CH_EIGHT;
                r.delay_ticks  = cfg_settle;
            end
            rtss_pkg::PH_YPOS: begin
                p = int'(cfg_pendown) - (int'(first_reading) - int'(second_reading));
                if (p < 0) p = 0;
                if (p > int'(rtss_pkg::PRESSURE_MAX)) p = int'(rtss_pkg::PRESSURE_MAX);
                r.sample_valid = 1'b1;
                r.pressure     = rtss_pkg::PRESSURE_W'(p);
                r.x_pos        = rtss_pkg::COORD_W'(x_reading);
                r.y_pos        = rtss_pkg::COORD_W'(value);
                pen_lifted     = 1'b0;
                scan_phase     = rtss_pkg::PH_PRESS1;
                r.drive_mode   = rtss_pkg::DRIVE_PRESSURE;
                r.next_channel = rtss_pkg::CH_NINE;
                r.delay_ticks  = cfg_settle;
            end
            default: begin
                scan_phase     = rtss_pkg::PH_PRESS1;
                r.drive_mode   = rtss_pkg::DRIVE_PRESSURE;
                r.next_channel = rtss_pkg::CH_NINE;
                r.delay_ticks  = cfg_idle;
            end
        endcase
        return r;
    endfunction

    // Choose a conversion; second pressure reads are steered to land as pen
    // down, pen up or transition so the scan gets past its pressure phases.
    function automatic logic [rtss_pkg::ADC_WIDTH_DEF-1:0] pick_conversion();
        int f;
        int lo;
        int hi;
        int kind;
        f    = int'(first_reading);
        kind = $urandom_range(0, 9);
        if (cfg_enable && scan_phase == rtss_pkg::PH_PRESS2) begin
            if (kind <= 4) begin
                lo = f - int'(cfg_pendown) + 1;
                hi = ADC_MAX;
            end else if (kind <= 7) begin
                lo = 0;
                hi = f - int'(cfg_penup) - 1;
            end else if (kind == 8) begin
                lo = f - int'(cfg_penup);
                hi = f - int'(cfg_pendown);
            end else begin
                lo = 0;
                hi = ADC_MAX;
            end
            if (lo < 0) lo = 0;
            if (hi > ADC_MAX) hi = ADC_MAX;
            if (lo <= hi) begin
                return rtss_pkg::ADC_WIDTH_DEF'($urandom_range(hi, lo));
            end
        end
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return rtss_pkg::ADC_WIDTH_DEF'($urandom);
        endcase
    endfunction

    // Offer one conversion request and record its expected result on acceptance.
    task automatic send_conversion(input logic [rtss_pkg::ADC_WIDTH_DEF-1:0] value);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_adc_value <= value;
        do @(posedge i_clk); while (!o_ready);
        expected_scans.push_back(predict_scan_step(value));
    endtask

    // Stop offering requests and wait until every expected result is back.
    task automatic wait_drained();
        if (i_valid) begin
            i_valid <= 1'b0;
        end
        while (expected_scans.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [rtss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rtss_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            rtss_pkg::REG_ENABLE:     cfg_enable     = data[0];
            rtss_pkg::REG_PENDOWN:    cfg_pendown    = rtss_pkg::GAP_W'(data);
            rtss_pkg::REG_PENUP:      cfg_penup      = rtss_pkg::GAP_W'(data);
            rtss_pkg::REG_SETTLE:     cfg_settle     = rtss_pkg::DELAY_W'(data);
            rtss_pkg::REG_TRANSITION: cfg_transition = rtss_pkg::DELAY_W'(data);
            rtss_pkg::REG_IDLE:       cfg_idle       = rtss_pkg::DELAY_W'(data);
            default: ;
        endcase
    endtask

    // Rewrite every register once the block has gone idle.
    task automatic program_registers(input logic en,
                                     input logic [rtss_pkg::GAP_W-1:0] pendown,
                                     input logic [rtss_pkg::GAP_W-1:0] penup,
                                     input logic [rtss_pkg::DELAY_W-1:0] settle,
                                     input logic [rtss_pkg::DELAY_W-1:0] transition,
                                     input logic [rtss_pkg::DELAY_W-1:0] idle);
        wait_drained();
        cfg_write(rtss_pkg::REG_ENABLE, rtss_pkg::CFG_DATA_W'(en));
        cfg_write(rtss_pkg::REG_PENDOWN, rtss_pkg::CFG_DATA_W'(pendown));
        cfg_write(rtss_pkg::REG_PENUP, rtss_pkg::CFG_DATA_W'(penup));
        cfg_write(rtss_pkg::REG_SETTLE, rtss_pkg::CFG_DATA_W'(settle));
        cfg_write(rtss_pkg::REG_TRANSITION, rtss_pkg::CFG_DATA_W'(transition));
        cfg_write(rtss_pkg::REG_IDLE, rtss_pkg::CFG_DATA_W'(idle));
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_defaults_enabled();
        program_registers(1'b1, rtss_pkg::PENDOWN_GAP_RST, rtss_pkg::PENUP_GAP_RST,
                          rtss_pkg::SETTLE_DELAY_RST, rtss_pkg::TRANS_DELAY_RST,
                          rtss_pkg::IDLE_DELAY_RST);
    endtask

    // Out of reset the block is disabled and must ignore conversions.
    task automatic test_disabled_block();
        send_conversion('0);
        send_conversion('1);
        send_conversion(12'hA5A);
    endtask

    // The first enabled conversion restarts the scan from its abnormal phase.
    task automatic test_scan_restart();
        program_defaults_enabled();
        send_conversion(12'h5A5);
    endtask

    // A touch, a lift, a repeated lift and a transition reading.
    task automatic test_touch_and_lift();
        send_conversion(12'd1000);
        send_conversion(12'd900);
        send_conversion('1);
        send_conversion('0);
        send_conversion('1);
        send_conversion('0);
        send_conversion('1);
        send_conversion('0);
        send_conversion(12'd2000);
        send_conversion(12'd1000);
    endtask

    // Differences equal to either gap count as neither pen down nor pen up.
    task automatic test_gap_boundaries();
        send_conversion(12'd1400);
        send_conversion(12'd1000);
        send_conversion(12'd3000);
        send_conversion(12'd1000);
    endtask

    // Highest pressure, and a pen-down gap lowered mid-scan so it clamps to zero.
    task automatic test_pressure_clamp();
        send_conversion('0);
        send_conversion('1);
        send_conversion('0);
        send_conversion('1);
        send_conversion(12'd1000);
        send_conversion(12'd700);
        program_registers(1'b1, '0, cfg_penup, cfg_settle, cfg_transition, cfg_idle);
        send_conversion(12'd123);
        send_conversion(12'd456);
        program_registers(1'b1, '1, cfg_penup, cfg_settle, cfg_transition, cfg_idle);
        send_conversion('0);
        send_conversion('1);
        send_conversion('0);
        send_conversion('1);
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_input_backpressure();
        int k;
        program_defaults_enabled();
        sender_gaps = 1'b0;
        drain_hold  = HOLDOFF_CYCLES;
        for (k = 0; k < 24; k++) begin
            send_conversion(pick_conversion());
        end
        wait_drained();
        sender_gaps = 1'b1;
    endtask

    task automatic run_scan_stream(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if (k % 50 == 0) begin
                sender_gaps   = $urandom_range(0, 2) != 0;
                receiver_gaps = $urandom_range(0, 2) != 0;
            end
            // Now and then the sender waits for the pipeline to empty.
            if ($urandom_range(0, 127) == 0) begin
                wait_drained();
            end
            send_conversion(pick_conversion());
        end
    endtask

    // Random scans under default, extreme and random register settings.
    task automatic test_random_scans();
        int                         s;
        int                         k;
        logic [rtss_pkg::GAP_W-1:0] pendown;
        for (s = 0; s < 8; s++) begin
            case (s)
                0: program_defaults_enabled();
                1: program_registers(1'b1, '0, '0, '0, '0, '0);
                2: program_registers(1'b1, '1, '1, '1, '1, '1);
                3: program_registers(1'b1, '1, '0, 8'd1, 8'd254, 8'd0);
                default: begin
                    pendown = rtss_pkg::GAP_W'($urandom_range(0, 1500));
                    program_registers(1'b1, pendown,
                                      rtss_pkg::GAP_W'($urandom_range(int'(pendown),
                                                                      ADC_MAX)),
                                      rtss_pkg::DELAY_W'($urandom),
                                      rtss_pkg::DELAY_W'($urandom),
                                      rtss_pkg::DELAY_W'($urandom));
                end
            endcase
            run_scan_stream(210);
            // A disabled stretch in the middle of a scan must leave it untouched.
            if (s % 2 == 1) begin
                program_registers(1'b0, cfg_pendown, cfg_penup, cfg_settle,
                                  cfg_transition, cfg_idle);
                for (k = 0; k < 6; k++) begin
                    send_conversion(pick_conversion());
                end
                program_registers(1'b1, cfg_pendown, cfg_penup, cfg_settle,
                                  cfg_transition, cfg_idle);
            end
        end
    endtask

    // Result ready: random stalls per result, plus any requested long hold-off.
    initial begin : result_ready_driver
        int low;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            low        = drain_hold + (receiver_gaps ? $urandom_range(0, 3) : 0);
            drain_hold = 0;
            if (low > 0) begin
                i_ready <= 1'b0;
                repeat (low) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            scan_mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_checker
        t_scan_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_scans.size() == 0) begin
                $error("result with no request outstanding: drive %0d delay %0d",
                       o_drive_mode, o_delay_ticks);
                scan_mismatches++;
            end else begin
                want = expected_scans.pop_front();
                check_field("accepted", want.accepted, o_accepted);
                check_field("drive_mode", want.drive_mode, o_drive_mode);
                check_field("next_channel", want.next_channel, o_next_channel);
                check_field("delay_ticks", want.delay_ticks, o_delay_ticks);
                check_field("sample_valid", want.sample_valid, o_sample_valid);
                check_field("pressure", want.pressure, o_pressure);
                check_field("x_pos", want.x_pos, o_x_pos);
                check_field("y_pos", want.y_pos, o_y_pos);
            end
        end
    end

    // End the run when nothing has moved on any port for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_disabled_block();
        test_scan_restart();
        test_touch_and_lift();
        test_gap_boundaries();
        test_pressure_clamp();
        test_input_backpressure();
        test_random_scans();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (scan_mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
design/rtss_pkg.sv
design/resistive_touch_scan_sequencer.sv
test/tb_resistive_touch_scan_sequencer.sv
